// ===== rtl/eswsm_pkg.sv =====
// Shared types and constants for the encoder sliding-window speed meter.
`default_nettype none
package eswsm_pkg;

	localparam int CHANNELS    = 4;
	localparam int LOCKOUT_W   = 16;
	localparam int PERIOD_W    = 20;
	localparam int RPM_W       = 8;
	localparam int SPEED_W     = 16;
	localparam int AGE_W       = 16;
	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 2;

	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = 2;
	localparam int FIFO_LVL_W  = 3;

	localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd1000;
	localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 20'd1000000;
	localparam logic [RPM_W-1:0]     RPM_RESET     = 8'd10;
	localparam logic [AGE_W-1:0]     AGE_MAX       = 16'hFFFF;
	localparam logic [SPEED_W-1:0]   SPEED_MAX     = 16'hFFFF;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LOCKOUT = 2'd0,
		CFG_PERIOD  = 2'd1,
		CFG_RPM     = 2'd2
	} cfg_index_t;

	typedef logic [CHANNELS-1:0][SPEED_W-1:0] result_t;

endpackage
`default_nettype wire

// ===== rtl/eswsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module eswsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/eswsm_fifo.sv =====
// Result queue between the speed pipeline and the output channel.
`default_nettype none
module eswsm_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire eswsm_pkg::result_t            push_data,
	output logic [eswsm_pkg::FIFO_LVL_W-1:0]   level,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output eswsm_pkg::result_t                 out_data
);
	import eswsm_pkg::*;

	result_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_LVL_W-1:0] level_q;
	logic                  pop;

	assign out_valid = (level_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = mem_q[rd_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + FIFO_LVL_W'(1);
				2'b01:   level_q <= level_q - FIFO_LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	overflow_a: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q < FIFO_LVL_W'(FIFO_DEPTH)) || pop)
		else $error("result queue overflow");

	underflow_a: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !push || (level_q != '0))
		else $error("result queue underflow");

	level_step_a: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (level_q == $past(level_q) + FIFO_LVL_W'(1)))
		else $error("result queue level out of step");

endmodule
`default_nettype wire

// ===== rtl/encoder_sliding_window_speed_meter.sv =====
// Encoder speed meter: per-channel edge lockout, pulse counting and windowed rpm reports.
//
// Usage. Each transfer on the input channel (in_valid, in_stall, edge_mask) is one
// timebase tick; bit n of edge_mask flags a rising edge on encoder channel n. An edge is
// counted when at least lockout_ticks ticks have passed since that channel's last
// counted edge. Every report_period_ticks ticks one result transfer leaves on the output
// channel (out_valid, out_stall, speed_wheel_0..3): count gained over the last
// WINDOW_SLOTS reports times rpm_per_pulse, saturated at 65535.
// Throughput: one tick per cycle while in_stall is low, also when every tick reports.
// A report moves through rep_s1, rep_s2 and the result queue to out_valid. The window
// snapshots live in a RAM of WINDOW_SLOTS rows, one read and one write per report;
// back-to-back reports to the same row are forwarded.
// A stalled receiver holds the result; up to four results queue, and in_stall rises only
// when the queue plus the reports still in the pipeline could fill it.
// Reset clears counts, edge ages, the period counter and the slot pointer; per-row valid
// bits make the snapshot RAM read as zero until written. Registers load from cfg_we,
// cfg_index and cfg_data; the user must write them while the block is idle: not enforced.
`default_nettype none
module encoder_sliding_window_speed_meter #(
	parameter int WINDOW_SLOTS = 3,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [eswsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [eswsm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [eswsm_pkg::CHANNELS-1:0]       edge_mask,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [eswsm_pkg::SPEED_W-1:0]             speed_wheel_0,
	output logic [eswsm_pkg::SPEED_W-1:0]             speed_wheel_1,
	output logic [eswsm_pkg::SPEED_W-1:0]             speed_wheel_2,
	output logic [eswsm_pkg::SPEED_W-1:0]             speed_wheel_3
);
	import eswsm_pkg::*;

	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int ROW_W  = CHANNELS * COUNT_WIDTH;
	localparam int PROD_W = COUNT_WIDTH + RPM_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);

	// configuration
	logic [LOCKOUT_W-1:0] lockout_q;
	logic [PERIOD_W-1:0]  period_ticks_q;
	logic [RPM_W-1:0]     rpm_q;

	// tick state
	logic [COUNT_WIDTH-1:0] cnt_q [CHANNELS];
	logic [AGE_W-1:0]       age_q [CHANNELS];
	logic [COUNT_WIDTH-1:0] cnt_d [CHANNELS];
	logic [AGE_W-1:0]       age_d [CHANNELS];
	logic [ROW_W-1:0]       cnt_row_d;
	logic [PERIOD_W-1:0]    period_q;
	logic [PERIOD_W:0]      period_next;
	logic                   report;
	logic [SLOT_W-1:0]      slot_q;
	logic [WINDOW_SLOTS-1:0] slot_valid_q;
	logic                   in_xfer;
	logic                   rd_en;
	logic                   same_row;

	// stage 1: snapshot read returns
	logic                   rep_s1;
	logic [SLOT_W-1:0]      slot_s1;
	logic [ROW_W-1:0]       cnt_s1;
	logic                   fwd_s1;
	logic [ROW_W-1:0]       fwd_data_s1;
	logic                   vld_s1;
	logic [ROW_W-1:0]       ram_rdata;
	logic [ROW_W-1:0]       snap_row;

	// stage 2: multiply and saturate
	logic                   rep_s2;
	logic [COUNT_WIDTH-1:0] delta_s2 [CHANNELS];
	result_t                result_d;

	logic [FIFO_LVL_W-1:0]  fifo_level;
	result_t                out_data;
	logic [FIFO_LVL_W:0]    credit_need;

	// hold input while queued plus in-flight reports could fill the result queue
	assign credit_need = {1'b0, fifo_level} + (FIFO_LVL_W+1)'(rep_s1)
		+ (FIFO_LVL_W+1)'(rep_s2);
	assign in_stall = (credit_need >= (FIFO_LVL_W+1)'(FIFO_DEPTH));
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			cnt_d[c] = cnt_q[c];
			age_d[c] = age_q[c];
			if (edge_mask[c] && (age_q[c] >= lockout_q)) begin
				cnt_d[c] = cnt_q[c] + COUNT_WIDTH'(1);
				age_d[c] = '0;
			end
			if (age_d[c] != AGE_MAX) begin
				age_d[c] = age_d[c] + AGE_W'(1);
			end
			cnt_row_d[c*COUNT_WIDTH +: COUNT_WIDTH] = cnt_d[c];
		end
	end

	assign period_next = {1'b0, period_q} + (PERIOD_W+1)'(1);
	assign report      = (period_next >= {1'b0, period_ticks_q});
	assign rd_en       = in_xfer && report;
	assign same_row    = rep_s1 && (slot_s1 == slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q      <= LOCKOUT_RESET;
			period_ticks_q <= PERIOD_RESET;
			rpm_q          <= RPM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOCKOUT: lockout_q      <= cfg_data[LOCKOUT_W-1:0];
				CFG_PERIOD:  period_ticks_q <= cfg_data[PERIOD_W-1:0];
				CFG_RPM:     rpm_q          <= cfg_data[RPM_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				cnt_q[c] <= '0;
				age_q[c] <= '0;
			end
			period_q     <= '0;
			slot_q       <= '0;
			slot_valid_q <= '0;
			rep_s1       <= 1'b0;
			rep_s2       <= 1'b0;
		end else begin
			if (in_xfer) begin
				for (int c = 0; c < CHANNELS; c++) begin
					cnt_q[c] <= cnt_d[c];
					age_q[c] <= age_d[c];
				end
				period_q <= report ? '0 : period_next[PERIOD_W-1:0];
				if (report) begin
					slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
				end
			end
			if (rep_s1) begin
				slot_valid_q[slot_s1] <= 1'b1;
			end
			rep_s1 <= rd_en;
			rep_s2 <= rep_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			slot_s1     <= slot_q;
			cnt_s1      <= cnt_row_d;
			fwd_s1      <= same_row;
			fwd_data_s1 <= cnt_s1;
			vld_s1      <= slot_valid_q[slot_q];
		end
	end

	eswsm_ram #(
		.WIDTH (ROW_W),
		.DEPTH (WINDOW_SLOTS)
	) u_ring (
		.clk   (clk),
		.we    (rep_s1),
		.waddr (slot_s1),
		.wdata (cnt_s1),
		.re    (rd_en),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// row written in the cycle of the read comes from the forward register
	always_comb begin
		if (fwd_s1) begin
			snap_row = fwd_data_s1;
		end else if (vld_s1) begin
			snap_row = ram_rdata;
		end else begin
			snap_row = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rep_s1) begin
			for (int c = 0; c < CHANNELS; c++) begin
				delta_s2[c] <= cnt_s1[c*COUNT_WIDTH +: COUNT_WIDTH]
					- snap_row[c*COUNT_WIDTH +: COUNT_WIDTH];
			end
		end
	end

	always_comb begin
		logic [PROD_W-1:0] prod;
		prod = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			prod = PROD_W'(delta_s2[c]) * PROD_W'(rpm_q);
			result_d[c] = (prod > PROD_W'(SPEED_MAX)) ? SPEED_MAX : prod[SPEED_W-1:0];
		end
	end

	eswsm_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rep_s2),
		.push_data (result_d),
		.level     (fifo_level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign speed_wheel_0 = out_data[0];
	assign speed_wheel_1 = out_data[1];
	assign speed_wheel_2 = out_data[2];
	assign speed_wheel_3 = out_data[3];

	slot_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT)
		else $error("slot pointer out of range");

	fwd_single_slot_a: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_s1 && fwd_s1) |-> (WINDOW_SLOTS == 1))
		else $error("snapshot row forwarded with more than one slot");

	report_flow_a: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> rep_s1 ##1 rep_s2)
		else $error("report lost in pipeline");

	no_stall_credit_a: assert property (@(posedge clk) disable iff (!arst_n)
		rep_s2 |-> (fifo_level < FIFO_LVL_W'(FIFO_DEPTH)))
		else $error("report reached a full result queue");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the encoder speed meter: random ticks checked by a scoreboard.
module testbench;
	import eswsm_pkg::*;

	localparam int SLOTS        = 3;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	class speed_scoreboard;
		logic [LOCKOUT_W-1:0] lockout;
		logic [PERIOD_W-1:0]  period;
		logic [RPM_W-1:0]     rpm;
		logic [31:0]          pulses [CHANNELS];
		logic [AGE_W-1:0]     age [CHANNELS];
		logic [31:0]          snap [CHANNELS][SLOTS];
		int                   slot;
		logic [PERIOD_W-1:0]  ticks;
		result_t              speeds_due [$];
		int                   errors;

		function new();
			lockout = LOCKOUT_RESET;
			period  = PERIOD_RESET;
			rpm     = RPM_RESET;
			for (int c = 0; c < CHANNELS; c++) begin
				pulses[c] = '0;
				age[c]    = '0;
				for (int s = 0; s < SLOTS; s++) snap[c][s] = '0;
			end
			slot   = 0;
			ticks  = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LOCKOUT: lockout = data[LOCKOUT_W-1:0];
				CFG_PERIOD:  period  = data[PERIOD_W-1:0];
				CFG_RPM:     rpm     = data[RPM_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance one tick; queue the speeds when this tick closes a report period.
		function void take_tick(logic [CHANNELS-1:0] mask);
			logic [PERIOD_W:0] next;
			logic [31:0]       delta;
			logic [39:0]       prod;
			result_t           speed;
			for (int c = 0; c < CHANNELS; c++) begin
				if (mask[c] && age[c] >= lockout) begin
					pulses[c] = pulses[c] + 32'd1;
					age[c]    = '0;
				end
				if (age[c] != AGE_MAX) age[c] = age[c] + 1'b1;
			end
			next = {1'b0, ticks} + 1'b1;
			if (next < {1'b0, period}) begin
				ticks = next[PERIOD_W-1:0];
				return;
			end
			ticks = '0;
			for (int c = 0; c < CHANNELS; c++) begin
				delta = pulses[c] - snap[c][slot];
				prod  = delta * rpm;
				speed[c] = (prod > SPEED_MAX) ? SPEED_MAX : prod[SPEED_W-1:0];
				snap[c][slot] = pulses[c];
			end
			slot = (slot + 1) % SLOTS;
			speeds_due.push_back(speed);
		endfunction

		function int pending();
			return speeds_due.size();
		endfunction

		task report_mismatch(string msg);
			if (errors < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_speeds(result_t got);
			result_t want;
			if (speeds_due.size() == 0) begin
				report_mismatch($sformatf("result %h with none expected", got));
				return;
			end
			want = speeds_due.pop_front();
			for (int c = 0; c < CHANNELS; c++)
				if (got[c] !== want[c])
					report_mismatch($sformatf("wheel %0d speed %0d, expected %0d",
						c, got[c], want[c]));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [CHANNELS-1:0]    edge_mask;
	logic                   out_valid;
	logic                   out_stall;
	logic [SPEED_W-1:0]     speed_wheel_0;
	logic [SPEED_W-1:0]     speed_wheel_1;
	logic [SPEED_W-1:0]     speed_wheel_2;
	logic [SPEED_W-1:0]     speed_wheel_3;

	speed_scoreboard sb = new();
	bit tx_gaps     = 1'b1;
	bit rx_gaps     = 1'b1;
	bit rx_hold_req = 1'b0;
	int cycle_count = 0;

	encoder_sliding_window_speed_meter #(
		.WINDOW_SLOTS(SLOTS),
		.COUNT_WIDTH (32)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.edge_mask    (edge_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.speed_wheel_0(speed_wheel_0),
		.speed_wheel_1(speed_wheel_1),
		.speed_wheel_2(speed_wheel_2),
		.speed_wheel_3(speed_wheel_3)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("encoder_sliding_window_speed_meter regression: fail");
			$finish;
		end
	end

	// Sample every transfer and register write at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_speeds({speed_wheel_3, speed_wheel_2, speed_wheel_1, speed_wheel_0});
			if (cfg_we) sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) sb.take_tick(edge_mask);
		end
	end

	// Receiver: random stall bursts, or one long hold on request.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				rx_hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 17);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task send_tick(logic [CHANNELS-1:0] mask);
		int gap;
		edge_mask <= mask;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop valid, wait for every queued result, then let the pipeline empty.
	task settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int                  n;
		int                  r;
		int                  rand_done;
		int                  phase;
		int                  wait_cnt;
		bit                  encoder_like;
		bit                  pause_mid;
		logic [CHANNELS-1:0] mask;
		int                  interval [CHANNELS];
		int                  cnt [CHANNELS];

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		edge_mask = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: every edge falls inside the first lockout.
		send_tick(4'hF);
		send_tick(4'h0);
		send_tick(4'h5);
		send_tick(4'hA);
		send_tick(4'hF);
		send_tick(4'h1);
		// Shorten the period below the running count: the next tick reports.
		settle();
		write_cfg(CFG_PERIOD, 20'd1);
		send_tick(4'hF);
		send_tick(4'hF);
		// Zero lockout, full scale, plus a write to the unused index.
		settle();
		write_cfg(CFG_LOCKOUT, {4'($urandom), 16'd0});
		write_cfg(CFG_RPM, {12'($urandom), 8'hFF});
		write_cfg(CFG_UNUSED, 20'($urandom));
		send_tick(4'hF);
		send_tick(4'hF);
		send_tick(4'hF);
		send_tick(4'h3);
		send_tick(4'hC);
		send_tick(4'h0);
		// Zero period reports on every tick.
		settle();
		write_cfg(CFG_PERIOD, 20'd0);
		send_tick(4'h9);
		send_tick(4'h6);
		settle();
		write_cfg(CFG_PERIOD, 20'hFFFFF);
		send_tick(4'hF);
		send_tick(4'hF);
		send_tick(4'h7);
		settle();
		write_cfg(CFG_RPM, 20'd0);
		write_cfg(CFG_PERIOD, 20'd2);
		send_tick(4'hE);
		send_tick(4'h1);
		send_tick(4'hF);

		// Dense edges over long windows drive the speed into saturation.
		settle();
		write_cfg(CFG_LOCKOUT, {4'($urandom), 16'd0});
		write_cfg(CFG_RPM, 20'hFF);
		write_cfg(CFG_PERIOD, 20'd100);
		for (int k = 0; k < 400; k++)
			send_tick(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF);
		rand_done = 400;

		phase = 0;
		while (rand_done < RANDOM_ITEMS) begin
			settle();
			write_cfg(CFG_LOCKOUT, {4'($urandom),
				16'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16))});
			write_cfg(CFG_PERIOD, (phase == 2) ? 20'd1 : 20'($urandom_range(1, 40)));
			r = $urandom_range(0, 9);
			write_cfg(CFG_RPM, {12'($urandom),
				8'((r == 0) ? 0 : (r < 3) ? 255 : $urandom_range(0, 255))});
			if (phase == 2) begin
				// Hold the receiver while ticks keep coming, so the block backs up.
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
				rx_hold_req = 1'b1;
			end else begin
				tx_gaps = ($urandom_range(0, 3) != 0);
				rx_gaps = ($urandom_range(0, 3) != 0);
			end
			n = $urandom_range(60, 200);
			encoder_like = ($urandom_range(0, 4) != 0);
			pause_mid = (phase == 1) || ($urandom_range(0, 2) == 0);
			for (int c = 0; c < CHANNELS; c++) begin
				interval[c] = $urandom_range(1, 12);
				cnt[c] = $urandom_range(0, interval[c]);
			end
			for (int k = 0; k < n; k++) begin
				if (pause_mid && k == n / 2) settle();
				if (encoder_like) begin
					mask = '0;
					for (int c = 0; c < CHANNELS; c++) begin
						if (cnt[c] == 0) begin
							mask[c] = 1'b1;
							cnt[c] = interval[c];
						end else begin
							cnt[c]--;
						end
					end
					// Inject contact chatter now and then.
					if ($urandom_range(0, 7) == 0) mask ^= 4'(1 << $urandom_range(0, 3));
				end else begin
					mask = 4'($urandom);
				end
				send_tick(mask);
			end
			rand_done += n;
			phase++;
		end

		// Last part, no idling: a report every tick, edges right at the lockout boundary.
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		settle();
		write_cfg(CFG_LOCKOUT, 20'd0);
		write_cfg(CFG_PERIOD, 20'd1);
		write_cfg(CFG_RPM, 20'hFF);
		send_tick(4'hF);
		settle();
		write_cfg(CFG_LOCKOUT, {4'($urandom), 16'd200});
		for (int k = 0; k < 198; k++) send_tick(4'h0);
		send_tick(4'h1);
		send_tick(4'h2);
		send_tick(4'h1);
		send_tick(4'h4);
		send_tick(4'h8);
		send_tick(4'hF);

		in_valid <= 1'b0;
		wait_cnt = 0;
		while (sb.pending() != 0 && wait_cnt < 5000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (20) @(negedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("encoder_sliding_window_speed_meter regression: pass");
		else
			$display("encoder_sliding_window_speed_meter regression: fail");
		$finish;
	end

endmodule
